/* design/dpcb_pkg.sv */
// ----------------------------------------------------------------------------
// dpcb_pkg
// Shared widths, constants and types for the depth-to-point-cloud crop unit.
// ----------------------------------------------------------------------------
package dpcb_pkg;

	localparam int COORD_W       = 18;
	localparam int DEPTH_W       = 16;
	localparam int RAY_W         = 16;
	localparam int MARGIN_W      = 16;
	localparam int COUNT_W       = 21;
	localparam int CFG_IDX_W     = 2;
	localparam int RAY_FRAC_BITS = 14;
	localparam int MAX_PIXELS    = 1048576;

	// kept count saturates at the smaller of MAX_PIXELS and the field maximum
	localparam logic [COUNT_W-1:0] COUNT_LIMIT =
		(MAX_PIXELS < (2**COUNT_W) - 1) ? COUNT_W'(MAX_PIXELS) : {COUNT_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOUND_EN   = 2'd0,
		CFG_BOX_MARGIN = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
	} box_t;

	typedef struct packed {
		logic joint_upd;   // a joint beat leaves the input stage
		logic frame_clr;   // the last pixel of a frame leaves the input stage
	} box_ctl_t;

endpackage

/* design/dpcb_box_track.sv */
// ----------------------------------------------------------------------------
// dpcb_box_track
// Running min/max of joint positions on every axis, cleared at frame end.
// ----------------------------------------------------------------------------
module dpcb_box_track (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dpcb_pkg::box_ctl_t                    ctl,
	input  logic signed [dpcb_pkg::COORD_W-1:0]   joint_x,
	input  logic signed [dpcb_pkg::COORD_W-1:0]   joint_y,
	input  logic signed [dpcb_pkg::COORD_W-1:0]   joint_z,
	output dpcb_pkg::box_t                        box
);

	dpcb_pkg::box_t box_q;
	logic           awaiting_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q      <= '0;
			awaiting_q <= 1'b1;
		end else if (ctl.frame_clr) begin
			box_q      <= '0;
			awaiting_q <= 1'b1;
		end else if (ctl.joint_upd) begin
			awaiting_q <= 1'b0;
			if (awaiting_q) begin
				box_q.min_x <= joint_x;
				box_q.max_x <= joint_x;
				box_q.min_y <= joint_y;
				box_q.max_y <= joint_y;
				box_q.min_z <= joint_z;
				box_q.max_z <= joint_z;
			end else begin
				if (joint_x > box_q.max_x) box_q.max_x <= joint_x;
				if (joint_y > box_q.max_y) box_q.max_y <= joint_y;
				if (joint_z > box_q.max_z) box_q.max_z <= joint_z;
				if (joint_x < box_q.min_x) box_q.min_x <= joint_x;
				if (joint_y < box_q.min_y) box_q.min_y <= joint_y;
				if (joint_z < box_q.min_z) box_q.min_z <= joint_z;
			end
		end
	end

	assign box = box_q;

endmodule

/* design/dpcb_deproject.sv */
// ----------------------------------------------------------------------------
// dpcb_deproject
// Ray slope times depth to millimetres, saturation, and the box keep test.
// ----------------------------------------------------------------------------
module dpcb_deproject (
	input  dpcb_pkg::box_t                        box,
	input  logic                                  bound_en,
	input  logic [dpcb_pkg::MARGIN_W-1:0]         margin,
	input  logic [dpcb_pkg::DEPTH_W-1:0]          depth_mm,
	input  logic signed [dpcb_pkg::RAY_W-1:0]     ray_x,
	input  logic signed [dpcb_pkg::RAY_W-1:0]     ray_y,
	input  logic                                  ray_valid,
	output logic signed [dpcb_pkg::COORD_W-1:0]   px,
	output logic signed [dpcb_pkg::COORD_W-1:0]   py,
	output logic                                  keep
);

	localparam int PROD_W = dpcb_pkg::RAY_W + dpcb_pkg::DEPTH_W + 1;
	localparam int LIM_W  = dpcb_pkg::COORD_W + 2;
	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((2**(dpcb_pkg::COORD_W-1)) - 1);
	localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-(2**(dpcb_pkg::COORD_W-1)));

	function automatic logic signed [dpcb_pkg::COORD_W-1:0] sat_coord(
		input logic signed [PROD_W-1:0] v
	);
		logic signed [PROD_W-1:0] r;
		begin
			if (v > SAT_HI)
				r = SAT_HI;
			else if (v < SAT_LO)
				r = SAT_LO;
			else
				r = v;
			return r[dpcb_pkg::COORD_W-1:0];
		end
	endfunction

	function automatic logic in_range(
		input logic signed [LIM_W-1:0] v,
		input logic signed [dpcb_pkg::COORD_W-1:0] lo,
		input logic signed [dpcb_pkg::COORD_W-1:0] hi,
		input logic signed [LIM_W-1:0] m
	);
		logic signed [LIM_W-1:0] lo_w;
		logic signed [LIM_W-1:0] hi_w;
		begin
			lo_w = LIM_W'(lo) - m;
			hi_w = LIM_W'(hi) + m;
			return (v >= lo_w) && (v <= hi_w);
		end
	endfunction

	logic signed [PROD_W-1:0] depth_s;
	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;
	logic signed [LIM_W-1:0]  margin_s;
	logic signed [LIM_W-1:0]  depth_lim;
	logic                     pix_ok;
	logic                     in_box;

	assign depth_s = $signed({{(PROD_W-dpcb_pkg::DEPTH_W){1'b0}}, depth_mm});
	assign prod_x  = PROD_W'(ray_x) * depth_s;
	assign prod_y  = PROD_W'(ray_y) * depth_s;

	// arithmetic shift floors toward minus infinity
	assign px = sat_coord(prod_x >>> dpcb_pkg::RAY_FRAC_BITS);
	assign py = sat_coord(prod_y >>> dpcb_pkg::RAY_FRAC_BITS);

	assign margin_s  = $signed({{(LIM_W-dpcb_pkg::MARGIN_W){1'b0}}, margin});
	assign depth_lim = $signed({{(LIM_W-dpcb_pkg::DEPTH_W){1'b0}}, depth_mm});

	assign in_box = in_range(LIM_W'(px), box.min_x, box.max_x, margin_s)
		&& in_range(LIM_W'(py), box.min_y, box.max_y, margin_s)
		&& in_range(depth_lim, box.min_z, box.max_z, margin_s);

	assign pix_ok = (depth_mm != '0) && ray_valid;
	assign keep   = pix_ok && (!bound_en || in_box);

endmodule

/* design/depth_to_point_cloud_box_crop_unit.sv */
// ----------------------------------------------------------------------------
// depth_to_point_cloud_box_crop_unit
// Joint beats (func 0) grow a per-frame bounding box and give no result; pixel
// beats (func 1) are deprojected to a point and give one result each, cropped
// to the box plus margin when bounding is on. The unit takes one beat per
// clock when the output side is not stalled: a beat is held in the input
// register, then the multiply and box test land a pixel's result in the
// output register, from which it is presented. Both stages hold under
// back-pressure; a joint beat in the input register leaves without waiting
// for the output side. Configuration writes are taken at once (cfg_ready is
// always high) and should only come while the unit is idle.
// ----------------------------------------------------------------------------
module depth_to_point_cloud_box_crop_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dpcb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dpcb_pkg::MARGIN_W-1:0]         cfg_data,
	// input items
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  func,
	input  logic signed [dpcb_pkg::COORD_W-1:0]   joint_x,
	input  logic signed [dpcb_pkg::COORD_W-1:0]   joint_y,
	input  logic signed [dpcb_pkg::COORD_W-1:0]   joint_z,
	input  logic [dpcb_pkg::DEPTH_W-1:0]          depth_mm,
	input  logic signed [dpcb_pkg::RAY_W-1:0]     ray_x,
	input  logic signed [dpcb_pkg::RAY_W-1:0]     ray_y,
	input  logic                                  ray_valid,
	input  logic                                  last_pixel,
	// results
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [dpcb_pkg::COORD_W-1:0]   point_x,
	output logic signed [dpcb_pkg::COORD_W-1:0]   point_y,
	output logic [dpcb_pkg::DEPTH_W-1:0]          point_z,
	output logic                                  point_valid,
	output logic [dpcb_pkg::COUNT_W-1:0]          points_so_far,
	output logic                                  frame_end
);

	// configuration registers
	logic                          bound_en_q;
	logic [dpcb_pkg::MARGIN_W-1:0] margin_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_en_q <= 1'b0;
			margin_q   <= dpcb_pkg::MARGIN_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dpcb_pkg::CFG_BOUND_EN:   bound_en_q <= cfg_data[0];
				dpcb_pkg::CFG_BOX_MARGIN: margin_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	logic                                vld_s1;
	logic                                func_s1;
	logic signed [dpcb_pkg::COORD_W-1:0] jx_s1;
	logic signed [dpcb_pkg::COORD_W-1:0] jy_s1;
	logic signed [dpcb_pkg::COORD_W-1:0] jz_s1;
	logic [dpcb_pkg::DEPTH_W-1:0]        depth_s1;
	logic signed [dpcb_pkg::RAY_W-1:0]   rx_s1;
	logic signed [dpcb_pkg::RAY_W-1:0]   ry_s1;
	logic                                rv_s1;
	logic                                last_s1;

	// output stage
	logic                                vld_s2;
	logic signed [dpcb_pkg::COORD_W-1:0] px_s2;
	logic signed [dpcb_pkg::COORD_W-1:0] py_s2;
	logic [dpcb_pkg::DEPTH_W-1:0]        pz_s2;
	logic                                keep_s2;
	logic [dpcb_pkg::COUNT_W-1:0]        count_s2;
	logic                                end_s2;

	logic [dpcb_pkg::COUNT_W-1:0]        kept_q;
	logic [dpcb_pkg::COUNT_W-1:0]        kept_next;

	logic                                out_free;
	logic                                s1_go;
	logic                                pixel_go;
	logic                                in_go;
	dpcb_pkg::box_ctl_t                  box_ctl;
	dpcb_pkg::box_t                      box;
	logic signed [dpcb_pkg::COORD_W-1:0] px;
	logic signed [dpcb_pkg::COORD_W-1:0] py;
	logic                                keep;

	assign out_free = !vld_s2 || out_ready;
	// joint beats only touch the box, so they leave regardless of the output
	assign s1_go    = vld_s1 && (!func_s1 || out_free);
	assign pixel_go = s1_go && func_s1;
	assign in_ready = !vld_s1 || s1_go;
	assign in_go    = in_valid && in_ready;

	assign box_ctl.joint_upd = s1_go && !func_s1;
	assign box_ctl.frame_clr = pixel_go && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_go) begin
			vld_s1 <= 1'b1;
		end else if (s1_go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			func_s1  <= func;
			jx_s1    <= joint_x;
			jy_s1    <= joint_y;
			jz_s1    <= joint_z;
			depth_s1 <= depth_mm;
			rx_s1    <= ray_x;
			ry_s1    <= ray_y;
			rv_s1    <= ray_valid;
			last_s1  <= last_pixel;
		end
	end

	dpcb_box_track u_box (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (box_ctl),
		.joint_x (jx_s1),
		.joint_y (jy_s1),
		.joint_z (jz_s1),
		.box     (box)
	);

	dpcb_deproject u_deproj (
		.box       (box),
		.bound_en  (bound_en_q),
		.margin    (margin_q),
		.depth_mm  (depth_s1),
		.ray_x     (rx_s1),
		.ray_y     (ry_s1),
		.ray_valid (rv_s1),
		.px        (px),
		.py        (py),
		.keep      (keep)
	);

	assign kept_next = (keep && (kept_q < dpcb_pkg::COUNT_LIMIT)) ?
		kept_q + dpcb_pkg::COUNT_W'(1) : kept_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
			vld_s2 <= 1'b0;
		end else begin
			if (pixel_go) begin
				kept_q <= last_s1 ? '0 : kept_next;
				vld_s2 <= 1'b1;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_go) begin
			px_s2    <= keep ? px : '0;
			py_s2    <= keep ? py : '0;
			pz_s2    <= keep ? depth_s1 : '0;
			keep_s2  <= keep;
			count_s2 <= kept_next;
			end_s2   <= last_s1;
		end
	end

	assign out_valid     = vld_s2;
	assign point_x       = px_s2;
	assign point_y       = py_s2;
	assign point_z       = pz_s2;
	assign point_valid   = keep_s2;
	assign points_so_far = count_s2;
	assign frame_end     = end_s2;

endmodule
